// ===== rtl/sapq_pkg.sv =====
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and constants for the sorted-array priority queue: payload
// structs, status codes, controller states and the datapath command group.
// ----------------------------------------------------------------------------
package sapq_pkg;

   localparam int VALUE_BITS   = 32;
   localparam int QSIZE_BITS   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [QSIZE_BITS-1:0] QSIZE_RESET = 5'd16;

   // register index, taken from the word address
   localparam logic REG_QUEUE_SIZE = 1'b0;

   // operation codes
   localparam logic MODE_INSERT  = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                          mode;
      logic signed [VALUE_BITS-1:0]  item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]                    status;
      logic signed [VALUE_BITS-1:0]  out_value;
   } rsp_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_HOLD
   } ctrl_state_type;

   typedef struct packed {
      logic op_go;
   } dp_cmd_type;

endpackage

// ===== rtl/sorted_array_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Ascending priority queue on a row of sorted slot cells with an APB-style
// register port for the number of slots in use.
// ----------------------------------------------------------------------------
// Usage:
//   req channel  : one transfer carries a mode (insert or dequeue) and a
//                  signed value; accepted when req_valid is high and
//                  req_stall is low.
//   rsp channel  : one transfer per request with a status and, on a good
//                  dequeue, the smallest stored value (zero otherwise).
//   csr port     : queue_size at byte address 0, read and write.
// The result is registered: it sits in the output register on the edge
// after acceptance. Throughput is one item per cycle unless stalled, set by
// the compare-and-shift that every slot cell performs in parallel against the
// incoming value (dequeue shifts every cell down by one in the same way).
// When the receiver stalls, the held result stays put and req_stall rises, so
// no new request is taken until the result is transferred.
// Reset empties the queue at once (no clearing pass) and sets queue_size to
// 16; slot contents are left as they are and never read before written.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sapq_pkg::req_type                    req_data,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sapq_pkg::rsp_type                    rsp_data,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sapq_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sapq_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sapq_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   sapq_pkg::dp_cmd_type             cmd;
   logic                             cfg_we;
   logic                             reg_sel;
   logic [sapq_pkg::QSIZE_BITS-1:0]  queue_size;

   // Decode on the word address; byte lane bits are ignored.
   assign reg_sel    = csr_paddr[2] == sapq_pkg::REG_QUEUE_SIZE;
   assign csr_pready = 1'b1;
   // Write the register on the access phase of a write transfer.
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel;
   // Return zero for any address beyond the register list.
   assign csr_prdata = reg_sel ? sapq_pkg::CSR_DATA_W'(queue_size) : '0;

   // Controller: owns the result handshake and issues one command per transfer.
   sapq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Datapath: slot cells, marks, size register and result register.
   sapq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .cfg_we     (cfg_we),
      .cfg_wdata  (csr_pwdata[sapq_pkg::QSIZE_BITS-1:0]),
      .queue_size (queue_size),
      .rsp_data   (rsp_data)
   );

   // Every accepted request yields a held result on the next edge.
   a_accept_gives_result : assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid
   ) else $error("accepted request produced no result");

   // Back-pressure on requests only while a result is waiting.
   a_stall_only_when_held : assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid
   ) else $error("request stalled with no result held");

   // Refused operations carry a zero value.
   a_refusal_zero_value : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != sapq_pkg::STATUS_DONE) |-> (rsp_data.out_value == '0)
   ) else $error("refused operation returned a non-zero value");

   // Status is never the unused code.
   a_status_legal : assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == sapq_pkg::STATUS_DONE ||
                     rsp_data.status == sapq_pkg::STATUS_FULL ||
                     rsp_data.status == sapq_pkg::STATUS_EMPTY)
   ) else $error("illegal status code");

endmodule

// ===== rtl/sapq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sapq_ctrl
// Handshake controller: tracks whether the result register holds a transfer
// that is not yet taken and tells the datapath when to execute an operation.
// ----------------------------------------------------------------------------
module sapq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sapq_pkg::dp_cmd_type  cmd
);

   sapq_pkg::ctrl_state_type state_ff;
   sapq_pkg::ctrl_state_type state_in;
   logic                     accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sapq_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   always_comb begin
      req_stall = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         sapq_pkg::CTRL_IDLE: begin
            req_stall = 1'b0;
            rsp_valid = 1'b0;
         end
         sapq_pkg::CTRL_HOLD: begin
            req_stall = rsp_stall;
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
            rsp_valid = 1'b0;
         end
      endcase
      accept    = req_valid && !req_stall;
      cmd.op_go = accept;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sapq_pkg::CTRL_IDLE: begin
            if (accept) begin
               state_in = sapq_pkg::CTRL_HOLD;
            end
         end
         sapq_pkg::CTRL_HOLD: begin
            if (!rsp_stall && !accept) begin
               state_in = sapq_pkg::CTRL_IDLE;
            end
         end
         default: begin
            state_in = sapq_pkg::CTRL_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/sapq_dpath.sv =====
// ----------------------------------------------------------------------------
// sapq_dpath
// Slot cells with parallel compare-and-shift, fill and count marks, the
// queue size register and the result register.
// ----------------------------------------------------------------------------
module sapq_dpath #(
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sapq_pkg::dp_cmd_type                  cmd,
   input  sapq_pkg::req_type                     req_data,
   input  logic                                  cfg_we,
   input  logic [sapq_pkg::QSIZE_BITS-1:0]       cfg_wdata,
   output logic [sapq_pkg::QSIZE_BITS-1:0]       queue_size,
   output sapq_pkg::rsp_type                     rsp_data
);

   localparam int MARK_W = $clog2(DEPTH + 1);
   localparam int CMP_W  = (MARK_W > sapq_pkg::QSIZE_BITS) ? MARK_W : sapq_pkg::QSIZE_BITS;
   localparam int VB     = sapq_pkg::VALUE_BITS;

   logic signed [VB-1:0]            cell_ff [DEPTH];
   logic signed [VB-1:0]            cell_in [DEPTH];
   logic [DEPTH-1:0]                ge;
   logic [MARK_W-1:0]               fill_ff, fill_in;
   logic [MARK_W-1:0]               count_ff, count_in;
   logic [sapq_pkg::QSIZE_BITS-1:0] qsize_ff;
   sapq_pkg::rsp_type               rsp_ff, rsp_in;
   logic [CMP_W-1:0]                eff_size;
   logic                            full;
   logic                            empty;
   logic                            do_insert;
   logic                            do_dequeue;

   always_comb begin
      eff_size = (CMP_W'(qsize_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(qsize_ff);
      full     = CMP_W'(fill_ff) >= eff_size;
      empty    = count_ff == '0;
      do_insert  = cmd.op_go && (req_data.mode == sapq_pkg::MODE_INSERT) && !full;
      do_dequeue = cmd.op_go && (req_data.mode == sapq_pkg::MODE_DEQUEUE) && !empty;
   end

   // each stored cell against the new value; only cells holding queue data count
   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic ge_prev;
         logic at_tail;

         assign ge[g] = (MARK_W'(g) < count_ff) && (cell_ff[g] >= req_data.item_value);
         assign at_tail = MARK_W'(g) == count_ff;

         if (g == 0) begin : g_first
            assign ge_prev = 1'b0;
         end else begin : g_rest
            assign ge_prev = ge[g-1];
         end

         always_comb begin
            cell_in[g] = cell_ff[g];
            if (do_insert) begin
               if (ge_prev) begin
                  cell_in[g] = (g == 0) ? cell_ff[g] : cell_ff[(g == 0) ? 0 : g-1];
               end else if (ge[g] || at_tail) begin
                  cell_in[g] = req_data.item_value;
               end
            end else if (do_dequeue) begin
               cell_in[g] = (g == DEPTH-1) ? cell_ff[g] : cell_ff[(g == DEPTH-1) ? g : g+1];
            end
         end

         always_ff @(posedge clock) begin
            cell_ff[g] <= cell_in[g];
         end
      end
   endgenerate

   always_comb begin
      fill_in  = fill_ff;
      count_in = count_ff;
      rsp_in   = rsp_ff;
      if (do_insert) begin
         fill_in  = fill_ff + MARK_W'(1);
         count_in = count_ff + MARK_W'(1);
      end else if (do_dequeue) begin
         count_in = count_ff - MARK_W'(1);
         if (count_ff == MARK_W'(1)) begin
            fill_in = '0;
         end
      end
      if (cmd.op_go) begin
         rsp_in.status    = sapq_pkg::STATUS_DONE;
         rsp_in.out_value = '0;
         if (req_data.mode == sapq_pkg::MODE_INSERT) begin
            if (full) begin
               rsp_in.status = sapq_pkg::STATUS_FULL;
            end
         end else if (empty) begin
            rsp_in.status = sapq_pkg::STATUS_EMPTY;
         end else begin
            rsp_in.out_value = cell_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
         qsize_ff <= sapq_pkg::QSIZE_RESET;
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
         if (cfg_we) begin
            qsize_ff <= cfg_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data   = rsp_ff;
   assign queue_size = qsize_ff;

endmodule
